>>> design/horizontal_red_blue_shift_top_assert.svh
// Assertion macros for the design files; hrbs_back is the one that includes them.
`ifndef HORIZONTAL_RED_BLUE_SHIFT_TOP_ASSERT_SVH
`define HORIZONTAL_RED_BLUE_SHIFT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define HRBS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define HRBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define HRBS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define HRBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> design/hrbs_pkg.sv
`default_nettype none

package hrbs_pkg;

    // Pixel as carried on tdata: red in the low byte.
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // Classification of one input beat, made by the front end.
    typedef struct packed {
        logic is_end;   // beat closes its row (tlast or row length limit)
        logic emit;     // beat releases at least one output pixel
        logic neg;      // latched shift is negative
    } flags_t;

    localparam int PIX_W       = 32;
    localparam int SHIFT_W     = 7;
    localparam int AMT_W       = 7;           // |shift|, 0..64
    localparam int AMT_TAB     = 1 << AMT_W;
    localparam int QUEUE_DEPTH = 4;

    // Register map: index taken from paddr[2].
    localparam logic REG_SHIFT_AMOUNT = 1'b0;

    function automatic int cmd_width(input int col_w, input int idx_w);
        return PIX_W + $bits(flags_t) + AMT_W + 3 * col_w + 3 * idx_w;
    endfunction

endpackage

`default_nettype wire

>>> design/hrbs_ram.sv
`default_nettype none

module hrbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/hrbs_queue.sv
`default_nettype none

module hrbs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  push_ready,
    output logic                  pop_valid,
    output logic      [WIDTH-1:0] pop_data,
    input  wire logic             pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> design/hrbs_front.sv
`default_nettype none

module hrbs_front #(
    parameter int WINDOW_DEPTH = 128,
    parameter int MAX_ROW_LEN  = 4096
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [hrbs_pkg::SHIFT_W-1:0] cfg_shift,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [31:0]                 s_tdata,
    input  wire logic                        s_tlast,
    input  wire logic                        q_ready,
    output logic                             q_push,
    output logic [hrbs_pkg::cmd_width((MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1,
                                      $clog2(WINDOW_DEPTH))-1:0] q_cmd
);

    localparam int COL_W = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int AMT_W = hrbs_pkg::AMT_W;
    localparam int CMP_W = (COL_W > AMT_W) ? COL_W : AMT_W;

    typedef struct packed {
        hrbs_pkg::pixel_t pix;
        hrbs_pkg::flags_t flags;
        logic [AMT_W-1:0] amt;
        logic [COL_W-1:0] last_col;
        logic [COL_W-1:0] start_col;
        logic [COL_W-1:0] stop_col;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] start_addr;
        logic [IDX_W-1:0] far_addr;
    } cmd_t;

    function automatic logic [IDX_W-1:0] sub_wrap(input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W-1:0] y);
        logic [IDX_W:0] d;
        d = {1'b0, x} - {1'b0, y};
        if (d[IDX_W]) begin
            d = d + (IDX_W + 1)'(WINDOW_DEPTH);
        end
        return d[IDX_W-1:0];
    endfunction

    // |shift| mod depth, built at elaboration
    logic [IDX_W-1:0] amod_tab [hrbs_pkg::AMT_TAB];
    for (genvar g = 0; g < hrbs_pkg::AMT_TAB; g++) begin : g_amod
        assign amod_tab[g] = IDX_W'(g % WINDOW_DEPTH);
    end

    logic [COL_W-1:0]             col_reg, col_next;
    logic [IDX_W-1:0]             ptr_reg, ptr_next;
    logic [hrbs_pkg::SHIFT_W-1:0] row_shift_reg, row_shift_next;

    logic [hrbs_pkg::SHIFT_W-1:0] shift_now;
    logic [AMT_W-1:0]             amt;
    logic [IDX_W-1:0]             amod;
    logic [CMP_W-1:0]             col_diff;
    logic                         c_ge_a;
    logic                         is_end;
    cmd_t                         cmd;

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    // first pixel of a row latches the configured shift
    assign shift_now = (col_reg == '0) ? cfg_shift : row_shift_reg;
    assign amt       = shift_now[hrbs_pkg::SHIFT_W-1] ? AMT_W'(-shift_now) : AMT_W'(shift_now);
    assign amod      = amod_tab[amt];
    assign c_ge_a    = CMP_W'(col_reg) >= CMP_W'(amt);
    assign col_diff  = CMP_W'(col_reg) - CMP_W'(amt);
    assign is_end    = s_tlast || (col_reg == COL_W'(MAX_ROW_LEN - 1));

    always_comb begin
        cmd.pix        = hrbs_pkg::pixel_t'(s_tdata);
        cmd.flags.is_end = is_end;
        cmd.flags.emit = is_end || c_ge_a;
        cmd.flags.neg  = shift_now[hrbs_pkg::SHIFT_W-1];
        cmd.amt        = amt;
        cmd.last_col   = col_reg;
        cmd.start_col  = c_ge_a ? col_diff[COL_W-1:0] : '0;
        cmd.stop_col   = is_end ? col_reg : cmd.start_col;
        cmd.wr_addr    = ptr_reg;
        cmd.start_addr = c_ge_a ? sub_wrap(ptr_reg, amod) : '0;
        cmd.far_addr   = sub_wrap(cmd.start_addr, amod);
    end

    assign q_cmd = cmd;

    always_comb begin
        col_next       = col_reg;
        ptr_next       = ptr_reg;
        row_shift_next = row_shift_reg;
        if (q_push) begin
            row_shift_next = shift_now;
            if (is_end) begin
                col_next = '0;
                ptr_next = '0;
            end else begin
                col_next = col_reg + COL_W'(1);
                ptr_next = (ptr_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            ptr_reg       <= '0;
            row_shift_reg <= '0;
        end else begin
            col_reg       <= col_next;
            ptr_reg       <= ptr_next;
            row_shift_reg <= row_shift_next;
        end
    end

endmodule

`default_nettype wire

>>> design/hrbs_back.sv
`default_nettype none

`include "horizontal_red_blue_shift_top_assert.svh"

module hrbs_back #(
    parameter int WINDOW_DEPTH = 128,
    parameter int MAX_ROW_LEN  = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire logic [hrbs_pkg::cmd_width((MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1,
                                           $clog2(WINDOW_DEPTH))-1:0] q_cmd,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    output logic             m_tlast
);

    localparam int COL_W = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int AMT_W = hrbs_pkg::AMT_W;
    localparam int CMP_W = (COL_W > AMT_W) ? COL_W : AMT_W;

    typedef struct packed {
        hrbs_pkg::pixel_t pix;
        hrbs_pkg::flags_t flags;
        logic [AMT_W-1:0] amt;
        logic [COL_W-1:0] last_col;
        logic [COL_W-1:0] start_col;
        logic [COL_W-1:0] stop_col;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] start_addr;
        logic [IDX_W-1:0] far_addr;
    } cmd_t;

    // per-output select bits, carried alongside the window read
    typedef struct packed {
        logic here_byp;
        logic far_byp;
        logic near_ok;
        logic far_ok;
        logic neg;
        logic last_px;
    } sel_t;

    function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] x);
        return (x == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : x + IDX_W'(1);
    endfunction

    cmd_t cmd;
    assign cmd = cmd_t'(q_cmd);

    // flush sequencer
    logic                  flush_reg, flush_next;
    logic [COL_W-1:0]      o_reg, o_next;
    logic [COL_W-1:0]      last_reg, last_next;
    logic [COL_W-1:0]      stop_reg, stop_next;
    logic [IDX_W-1:0]      here_addr_reg, here_addr_next;
    logic [IDX_W-1:0]      far_addr_reg, far_addr_next;
    logic [AMT_W-1:0]      amt_reg, amt_next;
    logic                  neg_reg, neg_next;
    logic                  end_reg, end_next;
    hrbs_pkg::pixel_t      pix_reg, pix_next;

    // read stage and output register
    logic                  s1_valid_reg, s1_valid_next;
    sel_t                  s1_sel_reg, s1_sel_next;
    hrbs_pkg::pixel_t      s1_pix_reg, s1_pix_next;
    logic                  m_valid_reg, m_valid_next;
    hrbs_pkg::pixel_t      m_pix_reg, m_pix_next;
    logic                  m_last_reg, m_last_next;

    logic                  out_load, advance, pop, issue;
    logic [COL_W-1:0]      e_col, e_last;
    logic [IDX_W-1:0]      e_here_addr, e_far_addr;
    logic [AMT_W-1:0]      e_amt;
    logic                  e_neg, e_end;
    hrbs_pkg::pixel_t      e_pix;
    logic [COL_W-1:0]      e_dist;
    sel_t                  e_sel;
    logic [31:0]           here_q, far_q;
    hrbs_pkg::pixel_t      here_px, far_px, near_px, out_px;

    assign out_load = !m_valid_reg || m_tready;
    assign advance  = !s1_valid_reg || out_load;
    assign pop      = !flush_reg && q_valid && advance;
    assign issue    = pop ? cmd.flags.emit : (flush_reg && advance);
    assign q_pop    = pop;

    // output pixel being set up this cycle
    assign e_col       = flush_reg ? o_reg : cmd.start_col;
    assign e_last      = flush_reg ? last_reg : cmd.last_col;
    assign e_here_addr = flush_reg ? here_addr_reg : cmd.start_addr;
    assign e_far_addr  = flush_reg ? far_addr_reg : cmd.far_addr;
    assign e_amt       = flush_reg ? amt_reg : cmd.amt;
    assign e_neg       = flush_reg ? neg_reg : cmd.flags.neg;
    assign e_end       = flush_reg ? end_reg : cmd.flags.is_end;
    assign e_pix       = flush_reg ? pix_reg : cmd.pix;
    assign e_dist      = e_last - e_col;

    always_comb begin
        // the near source (o + |shift|) is always the row's newest pixel when in range
        e_sel.near_ok  = CMP_W'(e_dist) >= CMP_W'(e_amt);
        e_sel.far_ok   = CMP_W'(e_col) >= CMP_W'(e_amt);
        e_sel.neg      = e_neg;
        e_sel.last_px  = e_end && (e_col == e_last);
        // window entry being written this cycle: take the beat itself
        e_sel.here_byp = pop && (e_here_addr == cmd.wr_addr);
        e_sel.far_byp  = pop && (e_far_addr == cmd.wr_addr);
    end

    hrbs_ram #(.WIDTH(hrbs_pkg::PIX_W), .DEPTH(WINDOW_DEPTH)) u_ram_here (
        .aclk  (aclk),
        .we    (pop),
        .waddr (cmd.wr_addr),
        .wdata (cmd.pix),
        .re    (issue),
        .raddr (e_here_addr),
        .rdata (here_q)
    );

    hrbs_ram #(.WIDTH(hrbs_pkg::PIX_W), .DEPTH(WINDOW_DEPTH)) u_ram_far (
        .aclk  (aclk),
        .we    (pop),
        .waddr (cmd.wr_addr),
        .wdata (cmd.pix),
        .re    (issue),
        .raddr (e_far_addr),
        .rdata (far_q)
    );

    always_comb begin
        flush_next     = flush_reg;
        o_next         = o_reg;
        last_next      = last_reg;
        stop_next      = stop_reg;
        here_addr_next = here_addr_reg;
        far_addr_next  = far_addr_reg;
        amt_next       = amt_reg;
        neg_next       = neg_reg;
        end_next       = end_reg;
        pix_next       = pix_reg;
        if (pop && cmd.flags.emit && (cmd.start_col != cmd.stop_col)) begin
            flush_next     = 1'b1;
            o_next         = cmd.start_col + COL_W'(1);
            last_next      = cmd.last_col;
            stop_next      = cmd.stop_col;
            here_addr_next = inc_wrap(cmd.start_addr);
            far_addr_next  = inc_wrap(cmd.far_addr);
            amt_next       = cmd.amt;
            neg_next       = cmd.flags.neg;
            end_next       = cmd.flags.is_end;
            pix_next       = cmd.pix;
        end else if (flush_reg && advance) begin
            if (o_reg == stop_reg) begin
                flush_next = 1'b0;
            end else begin
                o_next         = o_reg + COL_W'(1);
                here_addr_next = inc_wrap(here_addr_reg);
                far_addr_next  = inc_wrap(far_addr_reg);
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_sel_next   = s1_sel_reg;
        s1_pix_next   = s1_pix_reg;
        if (advance) begin
            s1_valid_next = issue;
            s1_sel_next   = e_sel;
            s1_pix_next   = e_pix;
        end
    end

    // combine window reads into the output pixel
    always_comb begin
        here_px = s1_sel_reg.here_byp ? s1_pix_reg : hrbs_pkg::pixel_t'(here_q);
        far_px  = s1_sel_reg.far_byp ? s1_pix_reg : hrbs_pkg::pixel_t'(far_q);
        near_px = s1_pix_reg;
        out_px.green = here_px.green;
        out_px.alpha = here_px.alpha;
        if (!s1_sel_reg.neg) begin
            out_px.red  = s1_sel_reg.near_ok ? near_px.red : 8'd0;
            out_px.blue = s1_sel_reg.far_ok ? far_px.blue : 8'd0;
        end else begin
            out_px.red  = s1_sel_reg.far_ok ? far_px.red : 8'd0;
            out_px.blue = s1_sel_reg.near_ok ? near_px.blue : 8'd0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_pix_next   = m_pix_reg;
        m_last_next  = m_last_reg;
        if (out_load) begin
            m_valid_next = s1_valid_reg;
            m_pix_next   = out_px;
            m_last_next  = s1_sel_reg.last_px;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flush_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            flush_reg    <= flush_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        o_reg         <= o_next;
        last_reg      <= last_next;
        stop_reg      <= stop_next;
        here_addr_reg <= here_addr_next;
        far_addr_reg  <= far_addr_next;
        amt_reg       <= amt_next;
        neg_reg       <= neg_next;
        end_reg       <= end_next;
        pix_reg       <= pix_next;
        s1_sel_reg    <= s1_sel_next;
        s1_pix_reg    <= s1_pix_next;
        m_pix_reg     <= m_pix_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pix_reg;
    assign m_tlast  = m_last_reg;

    `HRBS_ASSERT_IMPL(a_no_pop_in_flush, aclk, aresetn, flush_reg, !q_pop)
    `HRBS_ASSERT_IMPL(a_flush_col_range, aclk, aresetn, flush_reg, o_reg <= stop_reg)
    `HRBS_ASSERT_NEXT(a_s1_holds, aclk, aresetn, s1_valid_reg && !out_load, s1_valid_reg && $stable(s1_pix_reg) && $stable(s1_sel_reg))

endmodule

`default_nettype wire

>>> design/horizontal_red_blue_shift_top.sv
`default_nettype none

// Horizontal red/blue shift (chromatic aberration along rows). Pixels enter one
// beat per cycle in raster order on s_t*, tlast marking the last pixel of each
// row; each output beat on m_t* carries one pixel of the row in order, with
// red taken from the pixel shift_amount columns to the right and blue from
// shift_amount columns to the left (a negative shift swaps them), green and
// alpha unchanged, and zero in a channel whose source lies outside the row.
// The shift register is sampled on a row's first pixel, so a write in mid-row
// applies from the next row. Output lags input by |shift| pixels: no beat
// comes out for the first |shift| pixels of a row, then one beat per input
// beat, and the row's last pixel (tlast, or column MAX_ROW_LEN-1) releases the
// remaining min(column, |shift|) + 1 beats. Throughput is one pixel per cycle
// outside those bursts while m_tready is high; a burst holds the back end until
// its last beat issues, and the input keeps accepting until the 4-entry command
// queue fills. First output follows the releasing beat through the queue, the
// read stage and the output register. The pixel window is WINDOW_DEPTH entries
// of dual-copy RAM addressed by column modulo depth; results match a full
// window when WINDOW_DEPTH >= 2*|shift|+1. No clearing pass runs after reset.

module horizontal_red_blue_shift_top #(
    parameter int WINDOW_DEPTH = 128,
    parameter int MAX_ROW_LEN  = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input pixel channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    input  wire logic        s_tlast,   // row_end_in
    // output pixel channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic             m_tlast,   // row_end_out
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int COL_W = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CMD_W = hrbs_pkg::cmd_width(COL_W, IDX_W);

    // shift_amount register, 7-bit two's complement
    logic [hrbs_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        shift_next = shift_reg;
        if (cfg_wr && (paddr[2] == hrbs_pkg::REG_SHIFT_AMOUNT)) begin
            shift_next = pwdata[hrbs_pkg::SHIFT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= '0;
        end else begin
            shift_reg <= shift_next;
        end
    end

    // registers beyond the map read as zero; paddr[1:0] selects nothing
    assign prdata = (paddr[2] == hrbs_pkg::REG_SHIFT_AMOUNT) ? 32'(shift_reg) : 32'd0;

    // front end: column tracking, shift latch, beat classification
    logic             q_ready, q_push, q_valid, q_pop;
    logic [CMD_W-1:0] front_cmd, back_cmd;

    hrbs_front #(.WINDOW_DEPTH(WINDOW_DEPTH), .MAX_ROW_LEN(MAX_ROW_LEN)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_shift (shift_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_cmd     (front_cmd)
    );

    // command queue decouples input acceptance from row-end bursts
    hrbs_queue #(.WIDTH(CMD_W), .DEPTH(hrbs_pkg::QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (front_cmd),
        .push_ready (q_ready),
        .pop_valid  (q_valid),
        .pop_data   (back_cmd),
        .pop        (q_pop)
    );

    // back end: window RAM, flush sequencer, output register
    hrbs_back #(.WINDOW_DEPTH(WINDOW_DEPTH), .MAX_ROW_LEN(MAX_ROW_LEN)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (back_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
